FILE: rtl/csv_record_parser_defines.svh
// ----------------------------------------------------------------------------
// csv_record_parser_defines.svh
// Assertion helpers for the port-level checker file of the CSV record parser.
// ----------------------------------------------------------------------------
`ifndef CSV_RECORD_PARSER_DEFINES_SVH
`define CSV_RECORD_PARSER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define CSVP_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CSVP_ASSERT_NXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/csvp_pkg.sv
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared types and constants of the CSV record parser.
// ----------------------------------------------------------------------------
package csvp_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_ENABLE = 4'd1;

  localparam logic [7:0] DELIMITER_RESET = 8'd44;
  localparam logic [7:0] QUOTE_BYTE      = 8'h22;
  localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;

  // Widest internal fields over the whole parameter range
  localparam int FIDX_W = 6;
  localparam int FLEN_W = 16;
  localparam int LLEN_W = 20;

  // Decoupling queue between classifier and statistics
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    KIND_QUOTE      = 3'd0,
    KIND_DATA       = 3'd1,
    KIND_FIELD_END  = 3'd2,
    KIND_RECORD_END = 3'd3,
    KIND_INCOMPLETE = 3'd4
  } kind_t;

  // Classified byte, as handed from the front to the back
  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data;
    logic [FIDX_W-1:0] fidx;
    logic [FLEN_W-1:0] fpos;
    logic [FLEN_W-1:0] flen;
    logic [LLEN_W-1:0] llen;
    logic              ovf;
  } op_t;

  typedef struct packed {
    logic load;
    logic value;
  } hdr_load_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [3:0]  field_index;
    logic [7:0]  data_pos;
    logic        in_header;
    logic [7:0]  field_max_len;
    logic [31:0] line_count;
    logic [11:0] max_line_len;
    logic        overflow;
  } res_t;

endpackage

FILE: rtl/csvp_if.sv
// ----------------------------------------------------------------------------
// csvp_if
// Valid/ready channels of the CSV record parser: bytes in, results out and
// the configuration write port.
// ----------------------------------------------------------------------------
interface csvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

interface csvp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  out_byte;
  logic [3:0]  field_index;
  logic [7:0]  data_pos;
  logic        in_header;
  logic [7:0]  field_max_len;
  logic [31:0] line_count;
  logic [11:0] max_line_len;
  logic        overflow;

  modport source (output valid, kind, out_byte, field_index, data_pos, in_header,
                  field_max_len, line_count, max_line_len, overflow, input ready);
  modport sink   (input valid, kind, out_byte, field_index, data_pos, in_header,
                  field_max_len, line_count, max_line_len, overflow, output ready);
endinterface

interface csvp_cfg_if;
  import csvp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [7:0]           wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/csvp_queue.sv
// ----------------------------------------------------------------------------
// csvp_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module csvp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  csvp_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output csvp_pkg::op_t pop_op
);
  import csvp_pkg::*;

  op_t             slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != (Q_AW + 1)'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_op     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_AW'(1);
      if (push && !pop)      count <= count + (Q_AW + 1)'(1);
      else if (pop && !push) count <= count - (Q_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_op;
  end

endmodule

FILE: rtl/csvp_front.sv
// ----------------------------------------------------------------------------
// csvp_front
// Byte classifier: tracks quoting, field index, positions and lengths.
// ----------------------------------------------------------------------------
module csvp_front #(
  parameter int MAX_FIELDS      = 16,
  parameter int MAX_FIELD_BYTES = 255,
  parameter int MAX_LINE_BYTES  = 4095
) (
  input  logic          clk,
  input  logic          rst,
  csvp_in_if.sink       bytes,
  input  logic [7:0]    delimiter,
  output logic          push_valid,
  input  logic          push_ready,
  output csvp_pkg::op_t push_op
);
  import csvp_pkg::*;

  localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int PW = $clog2(MAX_FIELD_BYTES + 1);
  localparam int LW = $clog2(MAX_LINE_BYTES + 1);

  typedef enum logic [2:0] {
    MODE_OUT      = 3'b001,
    MODE_QUOTED   = 3'b010,
    MODE_UNQUOTED = 3'b100
  } mode_t;

  mode_t         mode, mode_next;
  logic [FW-1:0] cur_field, cur_field_next;
  logic [PW-1:0] byte_pos, byte_pos_next;
  logic [PW-1:0] fld_bytes, fld_bytes_next;
  logic [LW-1:0] rec_bytes, rec_bytes_next;

  logic          accept;
  logic          line_sat, flen_sat, bpos_sat;
  logic [LW-1:0] line_inc;
  logic [PW-1:0] flen_inc;
  logic [PW-1:0] bpos_inc;
  logic          quoted;

  assign bytes.ready = push_ready;
  assign accept      = bytes.valid && push_ready;
  assign quoted      = (mode == MODE_QUOTED);

  assign line_sat = (rec_bytes >= LW'(MAX_LINE_BYTES));
  assign line_inc = line_sat ? LW'(MAX_LINE_BYTES) : rec_bytes + LW'(1);
  assign flen_sat = (fld_bytes >= PW'(MAX_FIELD_BYTES));
  assign flen_inc = flen_sat ? PW'(MAX_FIELD_BYTES) : fld_bytes + PW'(1);
  assign bpos_sat = (byte_pos >= PW'(MAX_FIELD_BYTES));
  assign bpos_inc = bpos_sat ? PW'(MAX_FIELD_BYTES) : byte_pos + PW'(1);

  always_comb begin
    mode_next      = mode;
    cur_field_next = cur_field;
    byte_pos_next  = byte_pos;
    fld_bytes_next = fld_bytes;
    rec_bytes_next = rec_bytes;
    push_valid     = 1'b0;
    push_op.kind   = KIND_DATA;
    push_op.data   = 8'd0;
    push_op.fidx   = FIDX_W'(cur_field);
    push_op.fpos   = '0;
    push_op.flen   = FLEN_W'(fld_bytes);
    push_op.llen   = LLEN_W'(line_inc);
    push_op.ovf    = 1'b0;

    if (accept) begin
      if (bytes.end_of_input) begin
        // drop a bare end marker; report a partial record otherwise
        if (rec_bytes != '0) begin
          push_valid     = 1'b1;
          push_op.kind   = KIND_INCOMPLETE;
          push_op.llen   = '0;
          mode_next      = MODE_OUT;
          cur_field_next = '0;
          byte_pos_next  = '0;
          fld_bytes_next = '0;
          rec_bytes_next = '0;
        end
      end else begin
        push_valid     = 1'b1;
        push_op.ovf    = line_sat;
        rec_bytes_next = line_inc;
        if (!quoted && bytes.in_byte == delimiter) begin
          push_op.kind = KIND_FIELD_END;
          if (cur_field >= FW'(MAX_FIELDS - 1)) begin
            push_op.ovf = 1'b1;
          end else begin
            cur_field_next = cur_field + FW'(1);
          end
          byte_pos_next  = '0;
          fld_bytes_next = '0;
          mode_next      = MODE_OUT;
        end else if (!quoted && bytes.in_byte == NEWLINE_BYTE) begin
          push_op.kind   = KIND_RECORD_END;
          mode_next      = MODE_OUT;
          cur_field_next = '0;
          byte_pos_next  = '0;
          fld_bytes_next = '0;
          rec_bytes_next = '0;
        end else if ((mode == MODE_OUT || quoted) && bytes.in_byte == QUOTE_BYTE) begin
          push_op.kind   = KIND_QUOTE;
          push_op.ovf    = line_sat || flen_sat;
          fld_bytes_next = flen_inc;
          mode_next      = quoted ? MODE_OUT : MODE_QUOTED;
        end else begin
          push_op.kind   = KIND_DATA;
          push_op.data   = bytes.in_byte;
          push_op.ovf    = line_sat || flen_sat || bpos_sat;
          push_op.fpos   = bpos_sat ? FLEN_W'(MAX_FIELD_BYTES - 1) : FLEN_W'(byte_pos);
          fld_bytes_next = flen_inc;
          byte_pos_next  = bpos_inc;
          if (!quoted) mode_next = MODE_UNQUOTED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_OUT;
      cur_field <= '0;
      byte_pos  <= '0;
      fld_bytes <= '0;
      rec_bytes <= '0;
    end else begin
      mode      <= mode_next;
      cur_field <= cur_field_next;
      byte_pos  <= byte_pos_next;
      fld_bytes <= fld_bytes_next;
      rec_bytes <= rec_bytes_next;
    end
  end

endmodule

FILE: rtl/csvp_back.sv
// ----------------------------------------------------------------------------
// csvp_back
// Statistics unit: header tracking, per-field maximum table, record count,
// longest record, and the result register.
// ----------------------------------------------------------------------------
module csvp_back #(
  parameter int MAX_FIELDS      = 16,
  parameter int MAX_FIELD_BYTES = 255,
  parameter int MAX_LINE_BYTES  = 4095
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_ready,
  input  csvp_pkg::op_t      op_in,
  input  csvp_pkg::hdr_load_t hdr_load,
  csvp_out_if.source         results
);
  import csvp_pkg::*;

  localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int PW = $clog2(MAX_FIELD_BYTES + 1);
  localparam int LW = $clog2(MAX_LINE_BYTES + 1);

  logic            exec_valid;
  op_t             exec_op;
  logic            exec_fire;
  logic            pop;

  logic [PW-1:0]   tbl_mem [MAX_FIELDS];
  logic [PW-1:0]   tbl_rdata;
  logic [MAX_FIELDS-1:0] tbl_valid;
  logic            tbl_we;
  logic [FW-1:0]   pop_addr;
  logic [FW-1:0]   exec_addr;

  logic            fwd_valid;
  logic [FW-1:0]   fwd_addr;
  logic [PW-1:0]   fwd_data;

  logic [PW-1:0]   entry;
  logic [PW-1:0]   exec_flen;
  logic [PW-1:0]   fmax;
  logic [LW-1:0]   exec_llen;
  logic            is_close;
  logic            is_record;
  logic            upd;

  logic            header_pending;
  logic [31:0]     records, records_next;
  logic [LW-1:0]   longest, longest_next;

  logic            out_valid;
  res_t            out_res;
  res_t            res;

  assign exec_fire = exec_valid && (!out_valid || results.ready);
  assign op_ready  = !exec_valid || exec_fire;
  assign pop       = op_valid && op_ready;
  assign pop_addr  = FW'(op_in.fidx);
  assign exec_addr = FW'(exec_op.fidx);
  assign exec_flen = PW'(exec_op.flen);
  assign exec_llen = LW'(exec_op.llen);

  always_comb begin
    // a write on the edge of the read is not in the read data yet
    if (fwd_valid && fwd_addr == exec_addr) entry = fwd_data;
    else if (tbl_valid[exec_addr])          entry = tbl_rdata;
    else                                    entry = '0;

    is_close  = (exec_op.kind == KIND_FIELD_END) || (exec_op.kind == KIND_RECORD_END);
    is_record = (exec_op.kind == KIND_RECORD_END);
    upd       = is_close && !header_pending && (exec_flen >= entry);
    tbl_we    = exec_fire && upd;
    fmax      = is_close ? (upd ? exec_flen : entry) : '0;

    records_next = records;
    longest_next = longest;
    if (is_record && !header_pending) begin
      records_next = records + 32'd1;
      if (exec_llen >= longest) longest_next = exec_llen;
    end

    res.kind          = exec_op.kind;
    res.out_byte      = exec_op.data;
    res.field_index   = 4'(exec_op.fidx);
    res.data_pos      = 8'(exec_op.fpos);
    res.in_header     = header_pending;
    res.field_max_len = 8'(fmax);
    res.line_count    = records_next;
    res.max_line_len  = 12'(longest_next);
    res.overflow      = exec_op.ovf;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[exec_addr] <= exec_flen;
    if (pop)    tbl_rdata <= tbl_mem[pop_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_valid     <= 1'b0;
      fwd_valid      <= 1'b0;
      tbl_valid      <= '0;
      out_valid      <= 1'b0;
      header_pending <= 1'b1;
      records        <= '0;
      longest        <= '0;
    end else begin
      if (pop) begin
        exec_valid <= 1'b1;
        fwd_valid  <= tbl_we;
      end else if (exec_fire) begin
        exec_valid <= 1'b0;
      end
      if (tbl_we) tbl_valid[exec_addr] <= 1'b1;
      if (exec_fire) begin
        out_valid <= 1'b1;
        records   <= records_next;
        longest   <= longest_next;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (hdr_load.load) begin
        header_pending <= hdr_load.value;
      end else if (exec_fire && is_record && header_pending) begin
        header_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      exec_op  <= op_in;
      fwd_addr <= exec_addr;
      fwd_data <= exec_flen;
    end
    if (exec_fire) out_res <= res;
  end

  assign results.valid         = out_valid;
  assign results.kind          = out_res.kind;
  assign results.out_byte      = out_res.out_byte;
  assign results.field_index   = out_res.field_index;
  assign results.data_pos      = out_res.data_pos;
  assign results.in_header     = out_res.in_header;
  assign results.field_max_len = out_res.field_max_len;
  assign results.line_count    = out_res.line_count;
  assign results.max_line_len  = out_res.max_line_len;
  assign results.overflow      = out_res.overflow;

endmodule

FILE: rtl/csv_record_parser.sv
// ----------------------------------------------------------------------------
// csv_record_parser
// Byte-serial CSV field splitter with per-field and per-record statistics.
// ----------------------------------------------------------------------------
// Feed one text byte per request on "bytes"; each byte yields one result on
// "results" classifying it as a consumed quote, a field data byte, a field end
// or a record end, with the field index, data position, header flag and the
// running statistics (data record count, longest record, and the updated
// maximum length of the field just closed). An end-of-input request reports
// a dropped partial record, or nothing when no record is open. The block
// sustains one byte per clock cycle while results are taken; the classifier
// updates quote mode, field index and position counters as it takes each byte.
// A result passes through the queue, the execute register and the result
// register before it is presented, and the two-entry queue plus the result
// register let either side stall briefly without stopping the other. The
// per-field maximum table is cleared at reset through per-entry
// valid bits, so no clearing pass is needed and the block takes bytes from
// the first cycle after reset. Configuration writes (delimiter, header
// enable) are taken at any time but belong to idle periods; writing header
// enable also rearms (bit 0 set) or disables header detection for the next record.
// ----------------------------------------------------------------------------
module csv_record_parser #(
  parameter int MAX_FIELDS      = 16,
  parameter int MAX_FIELD_BYTES = 255,
  parameter int MAX_LINE_BYTES  = 4095
) (
  input  logic        clk,
  input  logic        rst,
  csvp_in_if.sink     bytes,
  csvp_out_if.source  results,
  csvp_cfg_if.sink    cfg
);
  import csvp_pkg::*;

  logic      [7:0] delimiter;
  logic            cfg_write;
  hdr_load_t       hdr_load;

  logic            q_push_valid;
  logic            q_push_ready;
  op_t             q_push_op;
  logic            q_pop_valid;
  logic            q_pop_ready;
  op_t             q_pop_op;

  // Configuration: always ready; writes the delimiter register or loads the header flag
  assign cfg.ready      = 1'b1;
  assign cfg_write      = cfg.valid && cfg.ready;
  assign hdr_load.load  = cfg_write && (cfg.reg_index == CFG_HEADER_ENABLE);
  assign hdr_load.value = cfg.wdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIMITER_RESET;
    end else if (cfg_write && cfg.reg_index == CFG_DELIMITER) begin
      delimiter <= cfg.wdata;
    end
  end

  // Front: classify each byte and advance the position counters
  csvp_front #(
    .MAX_FIELDS      (MAX_FIELDS),
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES),
    .MAX_LINE_BYTES  (MAX_LINE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .delimiter  (delimiter),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_op    (q_push_op)
  );

  // Queue: decouple classification from statistics
  csvp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_op    (q_push_op),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_op     (q_pop_op)
  );

  // Back: update the header flag, the field table and the record statistics
  csvp_back #(
    .MAX_FIELDS      (MAX_FIELDS),
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES),
    .MAX_LINE_BYTES  (MAX_LINE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (q_pop_valid),
    .op_ready (q_pop_ready),
    .op_in    (q_pop_op),
    .hdr_load (hdr_load),
    .results  (results)
  );

endmodule

FILE: rtl/csvp_checker.sv
// ----------------------------------------------------------------------------
// csvp_checker
// Port-level checks of the CSV record parser results, bound to the top level.
// ----------------------------------------------------------------------------
`include "csv_record_parser_defines.svh"

module csvp_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [2:0]  kind,
  input logic [7:0]  out_byte,
  input logic [7:0]  data_pos,
  input logic        in_header,
  input logic [31:0] line_count,
  input logic [11:0] max_line_len
);
  import csvp_pkg::*;

  logic        taken;
  logic        stalled;
  logic        hdr_taken;
  logic        non_data;
  logic        bare_payload;
  logic        count_ok;
  logic        stats_same;
  logic        longest_ok;
  logic [34:0] shown;
  logic [31:0] last_count;
  logic [11:0] last_max;

  assign taken        = valid && ready;
  assign stalled      = valid && !ready;
  assign hdr_taken    = taken && in_header;
  assign non_data     = valid && (kind != KIND_DATA);
  assign bare_payload = (out_byte == 8'd0) && (data_pos == 8'd0);
  assign count_ok     = (line_count == last_count) || (line_count == last_count + 32'd1);
  assign stats_same   = (line_count == last_count) && (max_line_len == last_max);
  assign longest_ok   = (max_line_len >= last_max);
  assign shown        = {kind, line_count};

  // hold the statistics of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
      last_max   <= '0;
    end else if (taken) begin
      last_count <= line_count;
      last_max   <= max_line_len;
    end
  end

  `CSVP_ASSERT_NXT(a_stall_hold, clk, rst, stalled, valid && $stable(shown), "held result moved")
  `CSVP_ASSERT_IMP(a_non_data_zero, clk, rst, non_data, bare_payload, "payload on non-data")
  `CSVP_ASSERT_IMP(a_count_step, clk, rst, taken, count_ok, "record count jumped")
  `CSVP_ASSERT_IMP(a_header_static, clk, rst, hdr_taken, stats_same, "header moved statistics")
  `CSVP_ASSERT_IMP(a_longest_grows, clk, rst, taken, longest_ok, "longest record shrank")

endmodule

bind csv_record_parser csvp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (results.valid),
  .ready        (results.ready),
  .kind         (results.kind),
  .out_byte     (results.out_byte),
  .data_pos     (results.data_pos),
  .in_header    (results.in_header),
  .line_count   (results.line_count),
  .max_line_len (results.max_line_len)
);

FILE: test/csvp_field_checker.sv
// ----------------------------------------------------------------------------
// csvp_field_checker
// Watches the byte, result and configuration channels of the CSV record
// parser, classifies each taken byte with its own copy of the parse state and
// compares every result field by field against the oldest awaited token.
// ----------------------------------------------------------------------------
module csvp_field_checker (
  input  logic clk,
  input  logic rst,
  csvp_in_if   bytes_mon,
  csvp_out_if  res_mon,
  csvp_cfg_if  cfg_mon,
  output int   fail_count,
  output int   outstanding,
  output int   checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import csvp_pkg::*;

  localparam int MAX_FIELDS      = 16;
  localparam int MAX_FIELD_BYTES = 255;
  localparam int MAX_LINE_BYTES  = 4095;
  localparam int PRINT_CAP       = 40;

  typedef enum logic [1:0] {SCAN_OUT, SCAN_QUOTED, SCAN_BARE} scan_mode_t;

  // Shadow parse state and settings
  logic [7:0]  delim;
  bit          hdr_pending;
  scan_mode_t  mode;
  int          cur_field;
  int          byte_pos;
  int          fld_bytes;
  int          rec_bytes;
  logic [31:0] records;
  int          longest;
  int          fmax_table [MAX_FIELDS];

  res_t awaited_tokens [$];
  int   fails = 0;
  int   seen  = 0;

  function automatic int sat_bump(input int v, input int lim, inout bit ovf);
    if (v >= lim) begin
      ovf = 1'b1;
      return lim;
    end
    return v + 1;
  endfunction

  // Header fields leave the table alone but still report the entry.
  function automatic int close_field();
    if (!hdr_pending && fld_bytes >= fmax_table[cur_field]) begin
      fmax_table[cur_field] = fld_bytes;
    end
    return fmax_table[cur_field];
  endfunction

  function automatic void drop_record();
    mode      = SCAN_OUT;
    cur_field = 0;
    byte_pos  = 0;
    fld_bytes = 0;
    rec_bytes = 0;
  endfunction

  // Advance the shadow state by one byte; return 0 when no result follows.
  function automatic bit classify_byte(input logic [7:0] b, input logic eoi, output res_t tok);
    bit         ovf;
    int         pos_out;
    int         max_out;
    int         idx_out;
    logic [7:0] data_out;
    kind_t      k;
    ovf       = 1'b0;
    pos_out   = 0;
    max_out   = 0;
    data_out  = 8'h00;
    tok       = '0;
    tok.in_header = hdr_pending;
    if (eoi) begin
      if (rec_bytes == 0) return 1'b0;
      k       = KIND_INCOMPLETE;
      idx_out = cur_field;
      drop_record();
    end else begin
      rec_bytes = sat_bump(rec_bytes, MAX_LINE_BYTES, ovf);
      idx_out   = cur_field;
      if (mode != SCAN_QUOTED && b == delim) begin
        k       = KIND_FIELD_END;
        max_out = close_field();
        if (cur_field >= MAX_FIELDS - 1) begin
          cur_field = MAX_FIELDS - 1;
          ovf       = 1'b1;
        end else begin
          cur_field++;
        end
        byte_pos  = 0;
        fld_bytes = 0;
        mode      = SCAN_OUT;
      end else if (mode != SCAN_QUOTED && b == NEWLINE_BYTE) begin
        k       = KIND_RECORD_END;
        max_out = close_field();
        if (hdr_pending) begin
          hdr_pending = 1'b0;
        end else begin
          records++;
          if (rec_bytes >= longest) longest = rec_bytes;
        end
        drop_record();
      end else if (mode != SCAN_BARE && b == QUOTE_BYTE) begin
        k         = KIND_QUOTE;
        fld_bytes = sat_bump(fld_bytes, MAX_FIELD_BYTES, ovf);
        mode      = (mode == SCAN_OUT) ? SCAN_QUOTED : SCAN_OUT;
      end else begin
        k        = KIND_DATA;
        data_out = b;
        if (mode != SCAN_QUOTED) mode = SCAN_BARE;
        fld_bytes = sat_bump(fld_bytes, MAX_FIELD_BYTES, ovf);
        if (byte_pos >= MAX_FIELD_BYTES) begin
          pos_out = MAX_FIELD_BYTES - 1;
          ovf     = 1'b1;
        end else begin
          pos_out = byte_pos;
        end
        byte_pos = sat_bump(byte_pos, MAX_FIELD_BYTES, ovf);
      end
    end
    tok.kind          = k;
    tok.out_byte      = data_out;
    tok.field_index   = 4'(idx_out);
    tok.data_pos      = 8'(pos_out);
    tok.field_max_len = 8'(max_out);
    tok.line_count    = records;
    tok.max_line_len  = 12'(longest);
    tok.overflow      = ovf;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      if (fails < PRINT_CAP) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    res_t exp_tok;
    if (rst) begin
      delim       = DELIMITER_RESET;
      hdr_pending = 1'b1;
      drop_record();
      records = '0;
      longest = 0;
      foreach (fmax_table[i]) fmax_table[i] = 0;
      awaited_tokens.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_index)
          CFG_DELIMITER:     delim = cfg_mon.wdata;
          CFG_HEADER_ENABLE: hdr_pending = cfg_mon.wdata[0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        seen++;
        if (awaited_tokens.size() == 0) begin
          if (fails < PRINT_CAP) begin
            $display("%0t: unexpected result, expected none, got kind %0d byte %0h",
                     $time, res_mon.kind, res_mon.out_byte);
          end
          fails++;
        end else begin
          exp_tok = awaited_tokens.pop_front();
          check_field("kind",          exp_tok.kind,          res_mon.kind);
          check_field("out_byte",      exp_tok.out_byte,      res_mon.out_byte);
          check_field("field_index",   exp_tok.field_index,   res_mon.field_index);
          check_field("data_pos",      exp_tok.data_pos,      res_mon.data_pos);
          check_field("in_header",     exp_tok.in_header,     res_mon.in_header);
          check_field("field_max_len", exp_tok.field_max_len, res_mon.field_max_len);
          check_field("line_count",    exp_tok.line_count,    res_mon.line_count);
          check_field("max_line_len",  exp_tok.max_line_len,  res_mon.max_line_len);
          check_field("overflow",      exp_tok.overflow,      res_mon.overflow);
        end
      end
      if (bytes_mon.valid && bytes_mon.ready) begin
        if (classify_byte(bytes_mon.in_byte, bytes_mon.end_of_input, exp_tok)) begin
          awaited_tokens.push_back(exp_tok);
        end
      end
    end
    fail_count  <= fails;
    outstanding <= awaited_tokens.size();
    checked     <= seen;
  end

endmodule

FILE: test/tb_csv_record_parser.sv
// ----------------------------------------------------------------------------
// tb_csv_record_parser
// Drives the CSV record parser with a short hand-written text covering quotes,
// reopened quoted fields, end-of-input and odd delimiters, then with phases of
// random records under different delimiter and header settings, with random
// stalls on both channels. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_csv_record_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import csvp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 110;
  localparam int DRAIN_CYCLES = 10;
  localparam int NUM_PHASES   = 6;

  logic clk;
  logic rst;
  int   cycle_cnt = 0;
  int   fail_count;
  int   outstanding;
  int   checked;

  // Idle control shared by the request driver and the result stall logic
  int idle_pct   = 20;
  bit no_idle    = 1'b0;
  int stall_left = 0;

  int         items_sent = 0;
  logic [7:0] cur_delim  = DELIMITER_RESET;
  logic [7:0] line_buf [$];

  // Settings per random phase: delimiter extremes, odd delimiters, header on/off
  logic [7:0] phase_delim [NUM_PHASES] = '{8'hFF, 8'h00, 8'h3B, DELIMITER_RESET,
                                           QUOTE_BYTE, 8'h09};
  bit         phase_hdr   [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
  int         phase_idle  [NUM_PHASES] = '{25, 10, 5, 0, 35, 0};

  // Hand-written opening text, default comma delimiter with header on:
  // header record "a",<FF>  then a data record with a 0x00 byte field, a closed
  // quoted field reopened in place, a bare tail and a quote taken as data.
  logic [7:0] opening_text [17] = '{
    QUOTE_BYTE, 8'h61, QUOTE_BYTE, DELIMITER_RESET, 8'hFF, NEWLINE_BYTE,
    8'h00, DELIMITER_RESET, QUOTE_BYTE, 8'h71, QUOTE_BYTE, QUOTE_BYTE,
    DELIMITER_RESET, QUOTE_BYTE, 8'h78, QUOTE_BYTE, NEWLINE_BYTE
  };

  csvp_in_if  bytes_ch ();
  csvp_out_if res_ch ();
  csvp_cfg_if cfg_ch ();

  csv_record_parser uut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  csvp_field_checker chk (
    .clk         (clk),
    .rst         (rst),
    .bytes_mon   (bytes_ch),
    .res_mon     (res_ch),
    .cfg_mon     (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a request or result never completes
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_csv_record_parser failed");
      $finish;
    end
  end

  // Result side: hold ready low for bursts of random length at random,
  // or keep it high for good once the quiet final phase starts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      res_ch.ready  <= 1'b0;
    end else if (!no_idle && $urandom_range(99) < idle_pct) begin
      stall_left    <= $urandom_range(13);
      res_ch.ready  <= 1'b0;
    end else begin
      res_ch.ready  <= 1'b1;
    end
  end

  // Issue one byte request and hold it until taken. Valid stays high on
  // return so back-to-back requests never drop it within a time step.
  task automatic push_request(input logic [7:0] b, input bit eoi);
    int gap;
    if (!no_idle && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(14, 1);
      bytes_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bytes_ch.valid        <= 1'b1;
    bytes_ch.in_byte      <= b;
    bytes_ch.end_of_input <= eoi;
    do @(posedge clk); while (!bytes_ch.ready);
    items_sent++;
  endtask

  // Drop valid, wait for every awaited result, then let the pipe settle so
  // that an end-of-input request with no result has also gone through.
  task automatic wait_idle();
    bytes_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high between the two.
  task automatic set_config(input logic [7:0] delim, input bit hdr);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= CFG_DELIMITER;
    cfg_ch.wdata     <= delim;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.reg_index <= CFG_HEADER_ENABLE;
    cfg_ch.wdata     <= {7'b0, hdr};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid     <= 1'b0;
    cur_delim = delim;
  endtask

  // Pick a content byte; outside quotes, avoid anything that would end the field.
  function automatic logic [7:0] text_byte(input bit quoted);
    logic [7:0] v;
    do begin
      v = $urandom_range(1) ? 8'($urandom_range(126, 32)) : 8'($urandom_range(255));
    end while (v == QUOTE_BYTE || (!quoted && (v == cur_delim || v == NEWLINE_BYTE)));
    return v;
  endfunction

  // Build one well-formed record in line_buf with random field content.
  task automatic fill_record(input int nfields, input int len_lo, input int len_hi);
    int len;
    bit quoted;
    line_buf.delete();
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) line_buf.push_back(cur_delim);
      quoted = ($urandom_range(99) < 30);
      len    = $urandom_range(len_hi, len_lo);
      if (quoted) line_buf.push_back(QUOTE_BYTE);
      for (int i = 0; i < len; i++) line_buf.push_back(text_byte(quoted));
      if (quoted) begin
        line_buf.push_back(QUOTE_BYTE);
        // Now and then follow the closing quote with a bare tail or a
        // reopened quoted part within the same field.
        case ($urandom_range(9))
          0: line_buf.push_back(text_byte(1'b0));
          1: begin
            line_buf.push_back(QUOTE_BYTE);
            line_buf.push_back(text_byte(1'b1));
            line_buf.push_back(QUOTE_BYTE);
          end
          default: ;
        endcase
      end
    end
    line_buf.push_back(NEWLINE_BYTE);
  endtask

  // One random unit of traffic: mostly whole records, some cut short by an
  // end-of-input request, some raw noise.
  task automatic random_step();
    int pick;
    int cut;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(6, 1)) push_request(8'($urandom), $urandom_range(4) == 0);
    end else begin
      if (pick < 13) begin
        fill_record($urandom_range(19, 15), 0, 3);     // past the last field index
      end else if (pick < 15) begin
        fill_record(1, 250, 262);                      // field position saturates
      end else begin
        fill_record($urandom_range(5, 1), 0, 6);
      end
      if (pick >= 90) begin
        cut = $urandom_range(line_buf.size() - 1);
        for (int i = 0; i < cut; i++) push_request(line_buf[i], 1'b0);
        push_request(8'($urandom), 1'b1);
      end else begin
        foreach (line_buf[i]) push_request(line_buf[i], 1'b0);
      end
    end
  endtask

  initial begin
    int phase_base;
    rst                   <= 1'b1;
    bytes_ch.valid        <= 1'b0;
    bytes_ch.in_byte      <= 8'h00;
    bytes_ch.end_of_input <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.reg_index      <= CFG_DELIMITER;
    cfg_ch.wdata          <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Opening text under reset settings, header on
    foreach (opening_text[i]) push_request(opening_text[i], 1'b0);
    push_request(8'hFF, 1'b1);            // nothing open: no result
    push_request(8'h7A, 1'b0);
    push_request(8'h00, 1'b1);            // partial record dropped

    // Delimiter equal to quote: the quote splits fields instead of quoting
    wait_idle();
    set_config(QUOTE_BYTE, 1'b0);
    push_request(8'h61, 1'b0);
    push_request(QUOTE_BYTE, 1'b0);
    push_request(NEWLINE_BYTE, 1'b0);

    // Delimiter equal to newline: records never end, end of input drops them
    wait_idle();
    set_config(NEWLINE_BYTE, 1'b1);
    push_request(8'h62, 1'b0);
    push_request(NEWLINE_BYTE, 1'b0);
    push_request(8'h00, 1'b1);

    // Random phases, each under its own settings; the last one runs flat out
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_config((p == NUM_PHASES - 1) ? 8'($urandom) : phase_delim[p], phase_hdr[p]);
      idle_pct = phase_idle[p];
      no_idle  = (p == NUM_PHASES - 1);
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS) random_step();
      push_request(8'($urandom), 1'b1);   // flush any open record
    end
    wait_idle();

    $display("Sent %0d byte requests under %0d register settings, %0d results compared.",
             items_sent, NUM_PHASES + 3, checked);
    $display("Covered quoted and bare fields, end of input, header records and saturation.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_csv_record_parser passed");
    end else begin
      $display("tb_csv_record_parser failed");
    end
    $finish;
  end

endmodule
